// ===== src/sspr_pkg.sv =====
package sspr_pkg;

  // Slot count and reply framing
  localparam int MAX_MOTORS  = 8;
  localparam int SLOT_W      = 8;
  localparam int FRAME_BYTES = 8;
  localparam logic [7:0] HDR_BYTE  = 8'hFF;
  localparam logic [7:0] REPLY_LEN = 8'd4;
  localparam int SIGN_BIT    = 15;

  // Register indexes on the configuration port
  localparam logic REG_MOTOR_IDS   = 1'b0;
  localparam logic REG_MOTOR_COUNT = 1'b1;

  // Input item kinds
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_START = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  // Result kinds
  typedef enum logic {
    REP_REPLY   = 1'b0,
    REP_SUMMARY = 1'b1
  } rep_kind_t;

endpackage

// ===== src/servo_status_reply_parser_core.sv =====
// Items pass through an input register; their results leave through an output register.
// Throughput: one item per cycle unless out_tready is low; while a result waits for
// out_tready, a new item is taken only if the input register is empty.
// Reset (rst_n, synchronous, active low) clears the byte window, the byte count, the
// filled slots, both configuration registers and the valid flags of both stages.
module servo_status_reply_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  input  logic [1:0]  in_tuser,    // [1:0] kind
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,   // [7:0] reply_id, [23:8] velocity, [31:24] slot_hits,
                                   // [39:32] filled_mask, [40] all_ok, [47:41] zero
  output logic        out_tuser,   // [0] report_kind
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  // Configuration registers
  logic [63:0] motor_ids_r;
  logic [3:0]  motor_count_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motor_ids_r   <= '0;
      motor_count_r <= '0;
    end else if (cfg_wr) begin
      if (cfg_paddr[3] == sspr_pkg::REG_MOTOR_IDS) begin
        motor_ids_r <= cfg_pwdata;
      end else begin
        motor_count_r <= cfg_pwdata[3:0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[3] == sspr_pkg::REG_MOTOR_IDS) begin
      cfg_prdata = motor_ids_r;
    end else begin
      cfg_prdata = {60'd0, motor_count_r};
    end
  end

  // Input register
  logic                in_valid_r;
  sspr_pkg::kind_t     in_kind_r;
  logic [7:0]          in_byte_r;
  logic                advance;
  logic                proc;

  assign advance   = !out_tvalid || out_tready;
  assign in_tready = !in_valid_r || advance;
  assign proc      = in_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_kind_r <= sspr_pkg::kind_t'(in_tuser);
      in_byte_r <= in_tdata;
    end
  end

  // Parser state
  logic [63:0] window_r, window_nxt;
  logic [3:0]  count_r, count_nxt;
  logic [sspr_pkg::SLOT_W-1:0] filled_r, filled_nxt;

  // Window shifted by the new byte and its fields (oldest byte in the top bits)
  logic [63:0] win_sh;
  logic [3:0]  count_inc;
  logic [7:0]  w_id, w_len, w_err, w_d0, w_d1, w_chk, w_sum;
  logic [15:0] enc;
  logic [15:0] vel;
  logic        frame_ok;

  assign win_sh    = {window_r[55:0], in_byte_r};
  assign count_inc = (count_r < 4'(sspr_pkg::FRAME_BYTES)) ? count_r + 4'd1 : count_r;
  assign w_id      = win_sh[47:40];
  assign w_len     = win_sh[39:32];
  assign w_err     = win_sh[31:24];
  assign w_d0      = win_sh[23:16];
  assign w_d1      = win_sh[15:8];
  assign w_chk     = win_sh[7:0];
  assign w_sum     = w_id + w_len + w_err + w_d0 + w_d1;
  assign enc       = {w_d1, w_d0};
  // sign-magnitude to two's complement; negative zero comes out as 0
  assign vel       = enc[sspr_pkg::SIGN_BIT] ? (16'd0 - {1'b0, enc[14:0]})
                                             : {1'b0, enc[14:0]};
  assign frame_ok  = (count_inc == 4'(sspr_pkg::FRAME_BYTES))
                     && (win_sh[63:56] == sspr_pkg::HDR_BYTE)
                     && (win_sh[55:48] == sspr_pkg::HDR_BYTE)
                     && (w_len == sspr_pkg::REPLY_LEN)
                     && (w_chk == ~w_sum);

  // Slots in use and id matches
  logic [3:0] used_cnt;
  logic [sspr_pkg::SLOT_W-1:0] used_mask;
  logic [sspr_pkg::SLOT_W-1:0] hits;

  assign used_cnt = (motor_count_r > 4'(sspr_pkg::MAX_MOTORS)) ?
                    4'(sspr_pkg::MAX_MOTORS) : motor_count_r;

  always_comb begin
    for (int k = 0; k < sspr_pkg::SLOT_W; k++) begin
      if (k < sspr_pkg::MAX_MOTORS) begin
        used_mask[k] = (4'(k) < used_cnt);
        hits[k]      = used_mask[k] && (motor_ids_r[8*k +: 8] == w_id);
      end else begin
        used_mask[k] = 1'b0;
        hits[k]      = 1'b0;
      end
    end
  end

  // Result staging
  logic        res_valid;
  logic        res_kind;
  logic [47:0] res_data;

  // Next state and result for the item in the input register
  always_comb begin
    window_nxt = window_r;
    count_nxt  = count_r;
    filled_nxt = filled_r;
    res_valid  = 1'b0;
    res_kind   = sspr_pkg::REP_REPLY;
    res_data   = '0;
    if (proc) begin
      case (in_kind_r)
        sspr_pkg::KIND_START: begin
          window_nxt = '0;
          count_nxt  = '0;
          filled_nxt = '0;
        end
        sspr_pkg::KIND_END: begin
          res_valid         = 1'b1;
          res_kind          = sspr_pkg::REP_SUMMARY;
          res_data[39:32]   = filled_r;
          res_data[40]      = ((filled_r & used_mask) == used_mask);
        end
        sspr_pkg::KIND_BYTE: begin
          window_nxt = win_sh;
          count_nxt  = count_inc;
          if (frame_ok) begin
            count_nxt = '0;
            if (hits != '0) begin
              filled_nxt      = filled_r | hits;
              res_valid       = 1'b1;
              res_data[7:0]   = w_id;
              res_data[23:8]  = vel;
              res_data[31:24] = hits;
              res_data[39:32] = filled_r | hits;
            end
          end
        end
        default: begin
          // kind 3: ignored
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      count_r  <= '0;
      filled_r <= '0;
    end else begin
      window_r <= window_nxt;
      count_r  <= count_nxt;
      filled_r <= filled_nxt;
    end
  end

  // Output register
  logic out_valid_r;
  logic out_kind_r;
  logic [47:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_kind_r <= res_kind;
      out_data_r <= res_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = out_data_r;

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 4'(sspr_pkg::FRAME_BYTES))
    else $error("byte count out of range");

  a_reply_hits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == sspr_pkg::REP_REPLY) |->
      (out_tdata[31:24] != 8'd0) && ((out_tdata[31:24] & ~out_tdata[39:32]) == 8'd0)
      && (out_tdata[40] == 1'b0))
    else $error("reply result with bad hits, fill or all_ok");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && in_kind_r == sspr_pkg::KIND_START) |=>
      (filled_r == '0) && (count_r == '0) && (window_r == '0))
    else $error("start item did not clear state");

  a_summary_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == sspr_pkg::REP_SUMMARY) |->
      (out_tdata[31:0] == 32'd0))
    else $error("summary carries reply fields");

endmodule
